FILE: rtl/max_heap_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core_defines
// Assertion macros shared by the heap queue RTL; empty bodies under SYNTH.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
// property holds at every clock edge out of reset
`define MHPQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
// antecedent implies consequent in the same cycle
`define MHPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MHPQ_ASSERT(label, expr, msg)
`define MHPQ_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Constants, codes and state type of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY = 15;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;     // holds a child index of any slot
    localparam int KEY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 4;
    localparam int OUT_W    = 40;             // status, key, count padded to bytes

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RM_LD,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

FILE: rtl/max_heap_priority_queue_core.sv
// Flow: a full insert or an empty remove goes straight to the result; an insert moves
//   the hole up toward the root until the key fits, a remove loads the root and last key
//   and moves the hole down until the key fits or a leaf is reached.
// Throughput: one item at a time, next item taken the cycle after the result loads;
//   each heap level costs a RAM read state and a compare/write state. Output stalls hold.
// Reset (rst_n, async): count cleared, queue idle, no result pending; heap RAM not cleared.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Bounded max-heap of signed keys held in RAM, hole-based sift up and down.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_core_defines.svh"

module max_heap_priority_queue_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mhpq_pkg::KEY_W-1:0] s_tdata,   // [31:0] key_in
    input  logic                       s_tuser,   // [0] req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mhpq_pkg::OUT_W-1:0] m_tdata    // [1:0] status, [33:2] key_out,
                                                  // [37:34] entry_count, [39:38] zero
);

    import mhpq_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;       // key that moves
    logic [STAT_W-1:0]        res_stat_reg, res_stat_next;
    logic signed [KEY_W-1:0]  res_key_reg, res_key_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        out_stat_reg, out_stat_next;
    logic signed [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [ECNT_W-1:0]        out_cnt_reg, out_cnt_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr0, ram_raddr1;
    logic signed [KEY_W-1:0]  ram_wdata, ram_rdata0, ram_rdata1;

    logic                     in_acc;
    logic                     out_free;
    logic [ADDR_W-1:0]        parent;
    logic [IDX_W-1:0]         left_idx, right_idx, n_ext;
    logic                     left_ok, right_ok;
    logic [ADDR_W-1:0]        best_pos;
    logic signed [KEY_W-1:0]  best_key;

    mhpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_key_reg, out_stat_reg};

    assign parent    = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_idx  = (IDX_W'(pos_reg) << 1) + IDX_W'(1);
    assign right_idx = left_idx + IDX_W'(1);
    assign n_ext     = IDX_W'(cnt_reg);
    assign left_ok   = left_idx < n_ext;
    assign right_ok  = right_idx < n_ext;

    // larger of the moving key and the two children; ties keep the parent
    always_comb
    begin
        best_pos = pos_reg;
        best_key = key_reg;
        if (left_ok && (ram_rdata0 > best_key))
        begin
            best_pos = left_idx[ADDR_W-1:0];
            best_key = ram_rdata0;
        end
        if (right_ok && (ram_rdata1 > best_key))
        begin
            best_pos = right_idx[ADDR_W-1:0];
            best_key = ram_rdata1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == REQ_INSERT)
                    begin
                        state_next = (cnt_reg >= CNT_W'(CAPACITY)) ? ST_FIN : ST_UP_RD;
                    end
                    else
                    begin
                        state_next = (cnt_reg == '0) ? ST_FIN : ST_RM_LD;
                    end
                end
            end
            ST_RM_LD:  state_next = ST_DN_RD;
            ST_UP_RD:  state_next = (pos_reg == '0) ? ST_FIN : ST_UP_CMP;
            ST_UP_CMP: state_next = (key_reg > ram_rdata0) ? ST_UP_RD : ST_FIN;
            ST_DN_RD:  state_next = left_ok ? ST_DN_CMP : ST_FIN;
            ST_DN_CMP: state_next = (best_pos != pos_reg) ? ST_DN_RD : ST_FIN;
            ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath, RAM control and result register
    always_comb
    begin
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        res_stat_next  = res_stat_reg;
        res_key_next   = res_key_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_key_next   = out_key_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = key_reg;
        ram_raddr0     = '0;
        ram_raddr1     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                res_stat_next = STAT_OK;
                res_key_next  = '0;
                key_next      = s_tdata;
                pos_next      = ADDR_W'(cnt_reg);
                ram_raddr1    = ADDR_W'(cnt_reg - CNT_W'(1));
                if (in_acc)
                begin
                    if (s_tuser == REQ_INSERT)
                    begin
                        if (cnt_reg >= CNT_W'(CAPACITY))
                        begin
                            res_stat_next = STAT_FULL;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_stat_next = STAT_EMPTY;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            ST_RM_LD:
            begin
                // root leaves as the result, last key starts at the root
                res_key_next = ram_rdata0;
                key_next     = ram_rdata1;
                pos_next     = '0;
            end
            ST_UP_RD:
            begin
                ram_raddr0 = parent;
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (key_reg > ram_rdata0)
                begin
                    ram_wdata = ram_rdata0;
                    pos_next  = parent;
                end
            end
            ST_DN_RD:
            begin
                ram_raddr0 = left_idx[ADDR_W-1:0];
                ram_raddr1 = right_ok ? right_idx[ADDR_W-1:0] : '0;
                if (!left_ok)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (best_pos != pos_reg)
                begin
                    ram_wdata = best_key;
                    pos_next  = best_pos;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_key_next   = res_key_reg;
                    out_cnt_next   = ECNT_W'(cnt_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        res_stat_reg <= res_stat_next;
        res_key_reg  <= res_key_next;
        out_stat_reg <= out_stat_next;
        out_key_reg  <= out_key_next;
        out_cnt_reg  <= out_cnt_next;
    end

    `MHPQ_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `MHPQ_ASSERT_IMPL(a_wr_range, ram_we, ram_waddr < ADDR_W'(CAPACITY),
        "heap write out of range")
    `MHPQ_ASSERT_IMPL(a_up_pos, (state_reg == ST_UP_RD) || (state_reg == ST_UP_CMP),
        pos_reg < ADDR_W'(cnt_reg), "sift up hole beyond count")
    `MHPQ_ASSERT_IMPL(a_full_cnt, out_valid_reg && (out_stat_reg == STAT_FULL),
        out_cnt_reg == ECNT_W'(CAPACITY), "full status with free slots")
    `MHPQ_ASSERT_IMPL(a_empty_res, out_valid_reg && (out_stat_reg == STAT_EMPTY),
        (out_cnt_reg == '0) && (out_key_reg == '0), "empty status with keys")

endmodule
